@@ hw/rtl/fspb_pkg.sv @@
// shared types, codes and crc helpers for the framed serial port bridge
package fspb_pkg;

  // framing bytes
  localparam logic [7:0] SOF_REQ    = 8'hA5;
  localparam logic [7:0] SOF_REP    = 8'h5A;
  localparam logic [7:0] FW_VERSION = 8'h01;

  // command codes
  localparam logic [7:0] CMD_SET_X = 8'h01;
  localparam logic [7:0] CMD_GET_Y = 8'h02;
  localparam logic [7:0] CMD_PULSE = 8'h03;
  localparam logic [7:0] CMD_PING  = 8'h04;

  // crc-16/ccitt
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;

  // width of len + overhead arithmetic
  localparam int TOT_W = 9;
  localparam logic [TOT_W-1:0] FRAME_OVERHEAD = 9'd5;

  // reply queue geometry
  localparam int TX_SLOTS = 8;
  localparam int TX_IDX_W = 3;
  localparam int TX_CNT_W = 4;
  localparam logic [TX_IDX_W-1:0] SLOT_CRC_HI = 3'd6;
  localparam logic [TX_IDX_W-1:0] SLOT_CRC_LO = 3'd7;
  localparam logic [TX_IDX_W-1:0] SLOT_Y_MID  = 3'd4;
  localparam logic [TX_IDX_W-1:0] SLOT_Y_LOW  = 3'd5;

  // one byte through the crc register, msb first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] data);
    logic [15:0] c;
    c = crc_in ^ {data, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

  // reply crcs that do not depend on any data
  localparam logic [15:0] CRC_SET_X_REP = crc_byte(crc_byte(CRC_INIT, CMD_SET_X), 8'h00);
  localparam logic [15:0] CRC_PULSE_REP = crc_byte(crc_byte(CRC_INIT, CMD_PULSE), 8'h00);
  localparam logic [15:0] CRC_PING_REP  =
    crc_byte(crc_byte(crc_byte(CRC_INIT, CMD_PING), 8'h01), FW_VERSION);
  localparam logic [15:0] CRC_GET_Y_PRE = crc_byte(crc_byte(CRC_INIT, CMD_GET_Y), 8'h03);

  // frame assembler status for one byte
  typedef struct packed {
    logic       done;
    logic       crc_ok;
    logic [7:0] cmd;
    logic [7:0] b3;
    logic [7:0] b4;
    logic [7:0] b5;
  } frame_evt_t;

  // reply queue load request
  typedef struct packed {
    logic [TX_CNT_W-1:0]          count;
    logic                         gety;
    logic [TX_SLOTS-1:0]          flags;
    logic [TX_SLOTS-1:0][7:0]     bytes;
  } tx_load_t;

endpackage

@@ hw/rtl/fspb_if.sv @@
// request and result channel interfaces
interface fspb_in_if #(
  parameter int Y_WIDTH = 21
) ();
  logic               valid;
  logic               ready;
  logic               func;
  logic [7:0]         rx_byte;
  logic [Y_WIDTH-1:0] y_pins;

  modport source (output valid, func, rx_byte, y_pins, input ready);
  modport sink   (input valid, func, rx_byte, y_pins, output ready);
endinterface

interface fspb_out_if #(
  parameter int X_WIDTH = 22
) ();
  logic               valid;
  logic               ready;
  logic               tx_valid;
  logic [7:0]         tx_byte;
  logic               tx_last;
  logic [X_WIDTH-1:0] x_bus;

  modport source (output valid, tx_valid, tx_byte, tx_last, x_bus, input ready);
  modport sink   (input valid, tx_valid, tx_byte, tx_last, x_bus, output ready);
endinterface

@@ hw/rtl/fspb_frame.sv @@
// request frame assembler: start hunt, length check and running crc
module fspb_frame
  import fspb_pkg::*;
#(
  parameter int FRAME_BYTES = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic [7:0] rx_byte,
  output frame_evt_t evt
);

  localparam int FILL_W = $clog2(FRAME_BYTES + 1);

  logic [FILL_W-1:0] fill_r, fill_nxt, fill_inc;
  logic [7:0]        cmd_r, cmd_nxt;
  logic [7:0]        len_r, len_nxt;
  logic [7:0]        b3_r, b3_nxt;
  logic [7:0]        b4_r, b4_nxt;
  logic [7:0]        b5_r, b5_nxt;
  logic [7:0]        prev_r, prev_nxt;
  logic [15:0]       crc_r, crc_nxt;
  logic [7:0]        len_cur;
  logic [TOT_W-1:0]  total;
  logic              start_ok;
  logic              stored;
  logic              done;

  always_comb begin
    fill_nxt = fill_r;
    cmd_nxt  = cmd_r;
    len_nxt  = len_r;
    b3_nxt   = b3_r;
    b4_nxt   = b4_r;
    b5_nxt   = b5_r;
    prev_nxt = prev_r;
    crc_nxt  = crc_r;
    done     = 1'b0;
    fill_inc = fill_r;

    len_cur  = (fill_r == FILL_W'(2)) ? rx_byte : len_r;
    total    = TOT_W'(len_cur) + FRAME_OVERHEAD;
    start_ok = (fill_r != '0) || (rx_byte == SOF_REQ);
    stored   = fill_r < FILL_W'(FRAME_BYTES);

    if (step && start_ok) begin
      if (stored) begin
        fill_inc = fill_r + FILL_W'(1);
        prev_nxt = rx_byte;
        if (fill_r == FILL_W'(1)) cmd_nxt = rx_byte;
        if (fill_r == FILL_W'(2)) len_nxt = rx_byte;
        if (fill_r == FILL_W'(3)) b3_nxt  = rx_byte;
        if (fill_r == FILL_W'(4)) b4_nxt  = rx_byte;
        if (fill_r == FILL_W'(5)) b5_nxt  = rx_byte;
        // crc covers cmd, len and payload only
        if (fill_r == '0) begin
          crc_nxt = CRC_INIT;
        end else if (TOT_W'(fill_r) + TOT_W'(3) <= total) begin
          crc_nxt = crc_byte(crc_r, rx_byte);
        end
      end
      fill_nxt = fill_inc;
      if (fill_inc >= FILL_W'(3)) begin
        if (total > TOT_W'(FRAME_BYTES)) begin
          fill_nxt = '0;
        end else if (TOT_W'(fill_inc) == total) begin
          fill_nxt = '0;
          done     = 1'b1;
        end
      end
    end
  end

  always_comb begin
    evt.done   = done;
    evt.crc_ok = (crc_r == {prev_r, rx_byte});
    evt.cmd    = cmd_r;
    evt.b3     = b3_nxt;
    evt.b4     = b4_nxt;
    evt.b5     = b5_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      cmd_r  <= '0;
      len_r  <= '0;
      b3_r   <= '0;
      b4_r   <= '0;
      b5_r   <= '0;
      prev_r <= '0;
      crc_r  <= CRC_INIT;
    end else begin
      fill_r <= fill_nxt;
      cmd_r  <= cmd_nxt;
      len_r  <= len_nxt;
      b3_r   <= b3_nxt;
      b4_r   <= b4_nxt;
      b5_r   <= b5_nxt;
      prev_r <= prev_nxt;
      crc_r  <= crc_nxt;
    end
  end

endmodule

@@ hw/rtl/fspb_txq.sv @@
// reply queue: holds up to eight results and sends them one per cycle while out_chan is ready
module fspb_txq
  import fspb_pkg::*;
#(
  parameter int X_WIDTH = 22
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              load,
  input  tx_load_t                          ld,
  input  logic [TX_SLOTS-1:0][X_WIDTH-1:0]  ld_x,
  output logic                              can_load,
  fspb_out_if.source                        out_chan
);

  logic [7:0]         ent_byte_r [TX_SLOTS];
  logic               ent_flag_r [TX_SLOTS];
  logic [X_WIDTH-1:0] ent_x_r    [TX_SLOTS];

  logic [TX_IDX_W-1:0] rd_r, rd_nxt;
  logic [TX_IDX_W-1:0] last_r, last_nxt;
  logic                busy_r, busy_nxt;
  logic                use_acc_r, use_acc_nxt;
  logic [1:0]          acc_cnt_r, acc_cnt_nxt;
  logic [15:0]         acc_r, acc_nxt;
  logic [TX_CNT_W-1:0] cnt_m1;
  logic                out_hs;
  logic                at_last;
  logic [7:0]          byte_sel;

  assign out_hs  = out_chan.valid && out_chan.ready;
  assign at_last = (rd_r == last_r);
  assign can_load = !busy_r || (out_hs && at_last);
  assign cnt_m1  = ld.count - TX_CNT_W'(1);

  always_comb begin
    rd_nxt      = rd_r;
    last_nxt    = last_r;
    busy_nxt    = busy_r;
    use_acc_nxt = use_acc_r;
    acc_cnt_nxt = acc_cnt_r;
    acc_nxt     = acc_r;

    if (out_hs) begin
      if (at_last) busy_nxt = 1'b0;
      else         rd_nxt   = rd_r + TX_IDX_W'(1);
    end

    if (load) begin
      busy_nxt = 1'b1;
      rd_nxt   = '0;
      last_nxt = cnt_m1[TX_IDX_W-1:0];
      if (ld.gety) begin
        // first payload byte now, the other two over the next cycles
        use_acc_nxt = 1'b1;
        acc_nxt     = crc_byte(CRC_GET_Y_PRE, ld.bytes[3]);
        acc_cnt_nxt = 2'd2;
      end else begin
        use_acc_nxt = 1'b0;
        acc_cnt_nxt = 2'd0;
      end
    end else if (acc_cnt_r != 2'd0) begin
      acc_nxt     = crc_byte(acc_r, (acc_cnt_r == 2'd2) ? ent_byte_r[SLOT_Y_MID]
                                                        : ent_byte_r[SLOT_Y_LOW]);
      acc_cnt_nxt = acc_cnt_r - 2'd1;
    end
  end

  always_comb begin
    byte_sel = ent_byte_r[rd_r];
    if (use_acc_r && rd_r == SLOT_CRC_HI) byte_sel = acc_r[15:8];
    if (use_acc_r && rd_r == SLOT_CRC_LO) byte_sel = acc_r[7:0];
  end

  assign out_chan.valid    = busy_r;
  assign out_chan.tx_valid = ent_flag_r[rd_r];
  assign out_chan.tx_byte  = byte_sel;
  assign out_chan.tx_last  = at_last;
  assign out_chan.x_bus    = ent_x_r[rd_r];

  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < TX_SLOTS; i++) begin
        ent_byte_r[i] <= ld.bytes[i];
        ent_flag_r[i] <= ld.flags[i];
        ent_x_r[i]    <= ld_x[i];
      end
    end
    acc_r <= acc_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r      <= '0;
      last_r    <= '0;
      busy_r    <= 1'b0;
      use_acc_r <= 1'b0;
      acc_cnt_r <= 2'd0;
    end else begin
      rd_r      <= rd_nxt;
      last_r    <= last_nxt;
      busy_r    <= busy_nxt;
      use_acc_r <= use_acc_nxt;
      acc_cnt_r <= acc_cnt_nxt;
    end
  end

endmodule

@@ hw/rtl/framed_serial_port_bridge_top.sv @@
// top level of the framed serial port bridge: input register, command execution, reply queue
//
//  channel   dir  handshake     payload
//  in_chan   in   valid/ready   func, rx_byte, y_pins
//  out_chan  out  valid/ready   tx_valid, tx_byte, tx_last, x_bus
//
// a request waits in the input register until the reply queue can take its results; they
// are built in one pass and loaded into the queue, which sends one result per cycle while
// out_chan is ready; a request gives 0 to 8 results and holds the queue until they are sent,
// and the next request is taken while the last result of the previous one is being taken
// synchronous active-low reset, no clearing pass
// out_chan stalls hold the queue and, behind it, the input register
module framed_serial_port_bridge_top
  import fspb_pkg::*;
#(
  parameter int FRAME_BYTES = 16,
  parameter int X_WIDTH     = 22,
  parameter int Y_WIDTH     = 21
) (
  input  logic       clk,
  input  logic       rst_n,
  fspb_in_if.sink    in_chan,
  fspb_out_if.source out_chan
);

  // input register
  logic               hold_v_r, hold_v_nxt;
  logic               hold_func_r;
  logic [7:0]         hold_byte_r;
  logic [Y_WIDTH-1:0] hold_y_r;

  // bus and pulse state
  logic [X_WIDTH-1:0] x_r, x_nxt;
  logic               pa_r, pa_nxt;
  logic [15:0]        pl_r, pl_nxt;
  logic [7:0]         pb_r, pb_nxt;

  logic               in_hs;
  logic               can_load;
  logic               process;
  logic               byte_step;
  frame_evt_t         evt;

  tx_load_t                          ld;
  logic [TX_SLOTS-1:0][X_WIDTH-1:0]  ld_x;
  logic                              ld_go;

  logic [31:0]        word32;
  logic [31:0]        y32;
  logic [X_WIDTH-1:0] x_set, x_set_clr, x_tick_clr;
  logic [15:0]        pl_dec;
  logic [15:0]        pulse_len;

  assign in_hs         = in_chan.valid && in_chan.ready;
  assign process       = hold_v_r && can_load;
  assign in_chan.ready = !hold_v_r || can_load;
  assign byte_step     = process && !hold_func_r;

  always_comb begin
    hold_v_nxt = hold_v_r;
    if (process) hold_v_nxt = 1'b0;
    if (in_hs)   hold_v_nxt = 1'b1;
  end

  fspb_frame #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_frame (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (byte_step),
    .rx_byte (hold_byte_r),
    .evt     (evt)
  );

  // operands of the commands
  assign word32     = {8'd0, evt.b3, evt.b4, evt.b5};
  assign y32        = 32'(hold_y_r);
  assign pulse_len  = {evt.b4, evt.b5};
  assign pl_dec     = pl_r - 16'd1;
  // an out-of-range bit index shifts the one out, so the bus stays as it is
  assign x_set      = x_r | (X_WIDTH'(1) << evt.b3);
  assign x_set_clr  = x_set & ~(X_WIDTH'(1) << evt.b3);
  assign x_tick_clr = x_r & ~(X_WIDTH'(1) << pb_r);

  always_comb begin
    x_nxt  = x_r;
    pa_nxt = pa_r;
    pl_nxt = pl_r;
    pb_nxt = pb_r;
    ld     = '0;
    for (int i = 0; i < TX_SLOTS; i++) ld_x[i] = x_r;

    if (process && hold_func_r) begin
      // microsecond tick
      if (pa_r) begin
        pl_nxt = pl_dec;
        if (pl_dec == 16'd0) begin
          pa_nxt   = 1'b0;
          x_nxt    = x_tick_clr;
          ld.count = TX_CNT_W'(5);
          ld.flags = 8'b0001_1111;
          ld.bytes[0] = SOF_REP;
          ld.bytes[1] = CMD_PULSE;
          ld.bytes[2] = 8'h00;
          ld.bytes[3] = CRC_PULSE_REP[15:8];
          ld.bytes[4] = CRC_PULSE_REP[7:0];
          for (int i = 0; i < TX_SLOTS; i++) ld_x[i] = x_tick_clr;
        end
      end
    end else if (byte_step && evt.done && !pa_r && evt.crc_ok) begin
      // a good frame, no pulse running
      case (evt.cmd)
        CMD_SET_X: begin
          x_nxt    = word32[X_WIDTH-1:0];
          ld.count = TX_CNT_W'(5);
          ld.flags = 8'b0001_1111;
          ld.bytes[0] = SOF_REP;
          ld.bytes[1] = CMD_SET_X;
          ld.bytes[2] = 8'h00;
          ld.bytes[3] = CRC_SET_X_REP[15:8];
          ld.bytes[4] = CRC_SET_X_REP[7:0];
          for (int i = 0; i < TX_SLOTS; i++) ld_x[i] = word32[X_WIDTH-1:0];
        end
        CMD_GET_Y: begin
          // crc bytes are finished inside the queue
          ld.count = TX_CNT_W'(8);
          ld.gety  = 1'b1;
          ld.flags = 8'b1111_1111;
          ld.bytes[0] = SOF_REP;
          ld.bytes[1] = CMD_GET_Y;
          ld.bytes[2] = 8'h03;
          ld.bytes[3] = y32[23:16];
          ld.bytes[4] = y32[15:8];
          ld.bytes[5] = y32[7:0];
        end
        CMD_PULSE: begin
          pb_nxt = evt.b3;
          pl_nxt = pulse_len;
          ld.bytes[0] = 8'h00;
          ld_x[0]     = x_set;
          if (pulse_len == 16'd0) begin
            // set and clear in the same request
            x_nxt    = x_set_clr;
            ld.count = TX_CNT_W'(6);
            ld.flags = 8'b0011_1110;
            ld.bytes[1] = SOF_REP;
            ld.bytes[2] = CMD_PULSE;
            ld.bytes[3] = 8'h00;
            ld.bytes[4] = CRC_PULSE_REP[15:8];
            ld.bytes[5] = CRC_PULSE_REP[7:0];
            for (int i = 1; i < TX_SLOTS; i++) ld_x[i] = x_set_clr;
          end else begin
            x_nxt    = x_set;
            pa_nxt   = 1'b1;
            ld.count = TX_CNT_W'(1);
          end
        end
        CMD_PING: begin
          ld.count = TX_CNT_W'(6);
          ld.flags = 8'b0011_1111;
          ld.bytes[0] = SOF_REP;
          ld.bytes[1] = CMD_PING;
          ld.bytes[2] = 8'h01;
          ld.bytes[3] = FW_VERSION;
          ld.bytes[4] = CRC_PING_REP[15:8];
          ld.bytes[5] = CRC_PING_REP[7:0];
        end
        default: begin
          // unknown command gives no reply
          ld.count = '0;
        end
      endcase
    end
  end

  assign ld_go = process && (ld.count != '0);

  fspb_txq #(
    .X_WIDTH (X_WIDTH)
  ) u_txq (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (ld_go),
    .ld       (ld),
    .ld_x     (ld_x),
    .can_load (can_load),
    .out_chan (out_chan)
  );

  // request payload register
  always_ff @(posedge clk) begin
    if (in_hs) begin
      hold_func_r <= in_chan.func;
      hold_byte_r <= in_chan.rx_byte;
      hold_y_r    <= in_chan.y_pins;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
      x_r      <= '0;
      pa_r     <= 1'b0;
      pl_r     <= '0;
      pb_r     <= '0;
    end else begin
      hold_v_r <= hold_v_nxt;
      x_r      <= x_nxt;
      pa_r     <= pa_nxt;
      pl_r     <= pl_nxt;
      pb_r     <= pb_nxt;
    end
  end

endmodule

@@ tb/fspb_checker.sv @@
`timescale 1ns / 100ps
// request/result monitor, bridge predictor and result comparison for the serial port bridge
module fspb_checker
  import fspb_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  fspb_in_if   in_mon,
  fspb_out_if  out_mon,
  output int   fail_count,
  output int   pending,
  output int   results_seen
);

  localparam int X_W       = 22;
  localparam int Y_W       = 21;
  localparam int FRAME_MAX = 16;

  typedef struct packed {
    logic           tx_valid;
    logic [7:0]     tx_byte;
    logic           tx_last;
    logic [X_W-1:0] x_bus;
  } bridge_res_t;

  // predicted bridge state
  logic [7:0]     fr_mem [FRAME_MAX];
  int             fr_fill;
  logic [X_W-1:0] xb;
  logic           pulse_on;
  logic [15:0]    pulse_cnt;
  logic [7:0]     pulse_bit;

  bridge_res_t reply_burst[$];
  bridge_res_t tx_expected[$];
  int          n_fail;
  int          n_res;

  // crc-16/ccitt, one data bit at a time
  function automatic logic [15:0] crc_next(input logic [15:0] c, input logic [7:0] d);
    logic [15:0] r;
    logic        fb;
    r = c;
    for (int i = 7; i >= 0; i--) begin
      fb = r[15] ^ d[i];
      r  = {r[14:0], 1'b0};
      if (fb) r = r ^ CRC_POLY;
    end
    return r;
  endfunction

  task automatic push_res(input logic v, input logic [7:0] b);
    reply_burst.push_back('{tx_valid: v, tx_byte: b, tx_last: 1'b0, x_bus: xb});
  endtask

  // reply frame: 5a, cmd, len, payload (msb first in pl), crc over cmd..payload
  task automatic push_reply(input logic [7:0] cmd, input int len, input logic [23:0] pl);
    logic [7:0]  fb [8];
    logic [15:0] c;
    int          n;
    fb[0] = SOF_REP;
    fb[1] = cmd;
    fb[2] = 8'(len);
    for (int i = 0; i < len; i++) fb[3+i] = pl[23-8*i -: 8];
    n = 3 + len;
    c = CRC_INIT;
    for (int i = 1; i < n; i++) c = crc_next(c, fb[i]);
    fb[n]   = c[15:8];
    fb[n+1] = c[7:0];
    n += 2;
    for (int i = 0; i < n; i++) push_res(1'b1, fb[i]);
  endtask

  task automatic drop_pulse_bit();
    if (pulse_bit < X_W) xb[pulse_bit] = 1'b0;
  endtask

  task automatic run_frame(input int total, input logic [Y_W-1:0] y);
    logic [15:0] got;
    logic [15:0] c;
    logic [23:0] word;
    logic [7:0]  cmd;
    if (pulse_on) return;
    got = {fr_mem[total-2], fr_mem[total-1]};
    c = CRC_INIT;
    for (int i = 1; i <= total - 3; i++) c = crc_next(c, fr_mem[i]);
    if (c != got) return;
    word = {fr_mem[3], fr_mem[4], fr_mem[5]};
    cmd  = fr_mem[1];
    case (cmd)
      CMD_SET_X: begin
        xb = word[X_W-1:0];
        push_reply(cmd, 0, 24'h0);
      end
      CMD_GET_Y: push_reply(cmd, 3, {3'b000, y});
      CMD_PULSE: begin
        pulse_bit = fr_mem[3];
        pulse_cnt = word[15:0];
        if (pulse_bit < X_W) xb[pulse_bit] = 1'b1;
        push_res(1'b0, 8'h00);
        if (pulse_cnt == 16'h0) begin
          drop_pulse_bit();
          push_reply(CMD_PULSE, 0, 24'h0);
        end else begin
          pulse_on = 1'b1;
        end
      end
      CMD_PING: push_reply(cmd, 1, {FW_VERSION, 16'h0});
      default: ;
    endcase
  endtask

  task automatic predict_req(input logic f, input logic [7:0] b, input logic [Y_W-1:0] y);
    int          total;
    bridge_res_t r;
    reply_burst.delete();
    if (f) begin
      if (pulse_on) begin
        pulse_cnt = pulse_cnt - 16'd1;
        if (pulse_cnt == 16'h0) begin
          pulse_on = 1'b0;
          drop_pulse_bit();
          push_reply(CMD_PULSE, 0, 24'h0);
        end
      end
    end else if (fr_fill != 0 || b == SOF_REQ) begin
      if (fr_fill < FRAME_MAX) begin
        fr_mem[fr_fill] = b;
        fr_fill++;
      end
      if (fr_fill >= 3) begin
        total = int'(fr_mem[2]) + int'(FRAME_OVERHEAD);
        if (total > FRAME_MAX) begin
          fr_fill = 0;
        end else if (fr_fill == total) begin
          fr_fill = 0;
          run_frame(total, y);
        end
      end
    end
    for (int i = 0; i < reply_burst.size(); i++) begin
      r = reply_burst[i];
      r.tx_last = (i == reply_burst.size() - 1);
      tx_expected.push_back(r);
    end
  endtask

  task automatic check_result();
    bridge_res_t want;
    n_res++;
    if (tx_expected.size() == 0) begin
      n_fail++;
      $error("unexpected result tx_valid %0d tx_byte %0h x_bus %0h",
             out_mon.tx_valid, out_mon.tx_byte, out_mon.x_bus);
      return;
    end
    want = tx_expected.pop_front();
    if (want.tx_valid !== out_mon.tx_valid) begin
      n_fail++;
      $error("tx_valid expected %0d actual %0d", want.tx_valid, out_mon.tx_valid);
    end
    if (want.tx_byte !== out_mon.tx_byte) begin
      n_fail++;
      $error("tx_byte expected %0h actual %0h", want.tx_byte, out_mon.tx_byte);
    end
    if (want.tx_last !== out_mon.tx_last) begin
      n_fail++;
      $error("tx_last expected %0d actual %0d", want.tx_last, out_mon.tx_last);
    end
    if (want.x_bus !== out_mon.x_bus) begin
      n_fail++;
      $error("x_bus expected %0h actual %0h", want.x_bus, out_mon.x_bus);
    end
  endtask

  initial begin
    n_fail = 0;
    n_res  = 0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < FRAME_MAX; i++) fr_mem[i] = 8'h00;
      fr_fill   = 0;
      xb        = '0;
      pulse_on  = 1'b0;
      pulse_cnt = 16'h0;
      pulse_bit = 8'h00;
      tx_expected.delete();
    end else begin
      // results of a request never leave at the edge that accepts it
      if (out_mon.valid && out_mon.ready) check_result();
      if (in_mon.valid && in_mon.ready) predict_req(in_mon.func, in_mon.rx_byte, in_mon.y_pins);
    end
    fail_count   <= n_fail;
    pending      <= tx_expected.size();
    results_seen <= n_res;
  end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// stimulus, idling phases and verdict for the framed serial port bridge
module tb_top
  import fspb_pkg::*;
();

  localparam int X_W = 22;
  localparam int Y_W = 21;

  logic clk = 1'b0;
  logic rst_n;

  always #1 clk = ~clk;

  fspb_in_if  #(.Y_WIDTH(Y_W)) in_chan ();
  fspb_out_if #(.X_WIDTH(X_W)) out_chan ();

  framed_serial_port_bridge_top #(
    .FRAME_BYTES(16),
    .X_WIDTH    (X_W),
    .Y_WIDTH    (Y_W)
  ) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan)
  );

  int fail_count;
  int pending;
  int results_seen;

  // the checker watches both channels and keeps the expected reply stream
  fspb_checker chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_chan),
    .out_mon     (out_chan),
    .fail_count  (fail_count),
    .pending     (pending),
    .results_seen(results_seen)
  );

  // idling knobs, percent of cycles
  int   idle_pct      = 0;
  int   stall_pct     = 0;
  logic long_hold_go  = 1'b0;
  int   req_count     = 0;
  int   frame_count   = 0;
  logic [7:0] pl_buf [11];

  // hard stop well past the slowest legal run
  initial begin
    #2000000;
    $display("tb_top: FAIL");
    $finish;
  end

  // receiver: random stalls, plus one long hold-off counted here
  initial begin
    int hold_left;
    hold_left = 0;
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_go) begin
        long_hold_go <= 1'b0;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // one request on the input channel; valid stays up into the next request
  task automatic send_req(input logic f, input logic [7:0] b, input logic [Y_W-1:0] y);
    while ($urandom_range(99) < idle_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid   <= 1'b1;
    in_chan.func    <= f;
    in_chan.rx_byte <= b;
    in_chan.y_pins  <= y;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    req_count++;
  endtask

  // a5, cmd, len, pl_buf[0..len-1], crc; y only matters on the closing byte
  task automatic send_frame(input logic [7:0] cmd, input int len, input logic [Y_W-1:0] y,
                            input bit bad_crc);
    logic [15:0] c;
    c = crc_byte(crc_byte(CRC_INIT, cmd), 8'(len));
    for (int i = 0; i < len; i++) c = crc_byte(c, pl_buf[i]);
    // corrupt a single crc bit
    if (bad_crc) c = c ^ (16'h1 << $urandom_range(15));
    send_req(1'b0, SOF_REQ, Y_W'($urandom));
    send_req(1'b0, cmd, Y_W'($urandom));
    send_req(1'b0, 8'(len), Y_W'($urandom));
    for (int i = 0; i < len; i++) send_req(1'b0, pl_buf[i], Y_W'($urandom));
    send_req(1'b0, c[15:8], Y_W'($urandom));
    send_req(1'b0, c[7:0], y);
    frame_count++;
  endtask

  task automatic send_cmd3(input logic [7:0] cmd, input logic [7:0] b0, input logic [7:0] b1,
                           input logic [7:0] b2, input logic [Y_W-1:0] y);
    pl_buf[0] = b0;
    pl_buf[1] = b1;
    pl_buf[2] = b2;
    send_frame(cmd, 3, y, 1'b0);
  endtask

  task automatic send_ticks(input int n);
    repeat (n) send_req(1'b1, 8'($urandom), Y_W'($urandom));
  endtask

  // zeros always close a partial frame within the longest frame length
  task automatic flush_hunt();
    repeat (16) send_req(1'b0, 8'h00, Y_W'($urandom));
  endtask

  // start byte, command and a length too big for the frame store
  task automatic send_oversized(input logic [7:0] len);
    send_req(1'b0, SOF_REQ, Y_W'($urandom));
    send_req(1'b0, 8'($urandom), Y_W'($urandom));
    send_req(1'b0, len, Y_W'($urandom));
  endtask

  // sender holds off until every predicted result is back, then lets the pipe settle
  task automatic drain_results();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // one random sequence: mostly good frames with random content
  task automatic random_seq();
    int         r;
    int         len;
    logic [7:0] cmd;
    r = $urandom_range(99);
    if (r < 72) begin
      case ($urandom_range(3))
        0:       cmd = CMD_SET_X;
        1:       cmd = CMD_GET_Y;
        2:       cmd = CMD_PULSE;
        default: cmd = CMD_PING;
      endcase
      len = (cmd == CMD_PING) ? 1 : 3;
      if ($urandom_range(9) == 0) len = $urandom_range(11);
      for (int i = 0; i < 11; i++) pl_buf[i] = 8'($urandom);
      if (cmd == CMD_PULSE) begin
        // bit index mostly within or just past the bus width, short durations
        pl_buf[0] = ($urandom_range(7) == 0) ? 8'($urandom) : 8'($urandom_range(X_W + 2));
        pl_buf[1] = 8'h00;
        pl_buf[2] = 8'($urandom_range(6));
      end
      send_frame(cmd, len, Y_W'($urandom), 1'b0);
      if (cmd == CMD_PULSE && $urandom_range(4) != 0) send_ticks(int'(pl_buf[2]));
    end else if (r < 80) begin
      for (int i = 0; i < 11; i++) pl_buf[i] = 8'($urandom);
      if ($urandom_range(1) == 0) begin
        send_frame(8'($urandom_range(CMD_PING) + 1), $urandom_range(3), Y_W'($urandom), 1'b1);
      end else begin
        // unknown command with a good crc
        cmd = ($urandom_range(3) == 0) ? 8'h00 : 8'($urandom_range(255, 5));
        send_frame(cmd, $urandom_range(3), Y_W'($urandom), 1'b0);
      end
    end else if (r < 88) begin
      send_ticks($urandom_range(4, 1));
    end else if (r < 93) begin
      repeat ($urandom_range(3, 1)) send_req(1'b0, 8'($urandom), Y_W'($urandom));
      flush_hunt();
    end else if (r < 97) begin
      send_oversized(8'($urandom_range(255, 12)));
    end else begin
      // frame cut short, then resync
      send_req(1'b0, SOF_REQ, Y_W'($urandom));
      send_req(1'b0, CMD_SET_X, Y_W'($urandom));
      send_req(1'b0, 8'h03, Y_W'($urandom));
      repeat ($urandom_range(3)) send_req(1'b0, 8'($urandom), Y_W'($urandom));
      flush_hunt();
    end
  endtask

  initial begin
    int target;
    rst_n           <= 1'b0;
    in_chan.valid   <= 1'b0;
    in_chan.func    <= 1'b0;
    in_chan.rx_byte <= 8'h00;
    in_chan.y_pins  <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed: every command and the corner cases, no idling
    pl_buf[0] = FW_VERSION;
    send_frame(CMD_PING, 1, Y_W'($urandom), 1'b0);
    send_cmd3(CMD_SET_X, 8'hFF, 8'hFF, 8'hFF, '0);         // masked to bus width
    send_cmd3(CMD_GET_Y, 8'h00, 8'h00, 8'h00, '1);         // all pins high
    send_cmd3(CMD_GET_Y, 8'hFF, 8'hFF, 8'hFF, '0);         // all pins low
    send_ticks(1);                                         // tick with no pulse running
    send_cmd3(CMD_PULSE, 8'd0, 8'h00, 8'h00, '0);          // zero-length pulse
    send_cmd3(CMD_PULSE, 8'd21, 8'h00, 8'h02, '0);         // top bit of the bus
    pl_buf[0] = FW_VERSION;
    send_frame(CMD_PING, 1, '0, 1'b0);                     // dropped, pulse running
    send_ticks(2);
    send_cmd3(CMD_PULSE, 8'd22, 8'h00, 8'h01, '0);         // index just past the bus
    send_ticks(1);
    send_cmd3(CMD_PULSE, 8'hFF, 8'h00, 8'h00, '0);
    send_frame(CMD_SET_X, 0, '0, 1'b0);                    // short payload reads the crc bytes and a stale byte
    send_oversized(8'd12);
    send_oversized(8'hFF);
    pl_buf[0] = FW_VERSION;
    send_frame(CMD_PING, 1, '0, 1'b1);                     // bad crc
    send_frame(8'h00, 0, '0, 1'b0);                        // unknown commands
    send_frame(8'hFF, 0, '0, 1'b0);
    for (int i = 0; i < 11; i++) pl_buf[i] = 8'($urandom);
    send_frame(CMD_SET_X, 11, '0, 1'b0);                   // longest frame that fits
    send_cmd3(CMD_SET_X, 8'h00, 8'h00, 8'h08, '0);
    send_cmd3(CMD_PULSE, 8'd3, 8'h00, 8'h01, '0);          // bit already high, still cleared
    send_ticks(1);
    send_cmd3(CMD_PULSE, 8'd7, 8'h00, 8'h28, '0);          // long pulse, 40 ticks
    send_ticks(40);
    drain_results();

    // random phases: none, sender idle, receiver stall, both
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct <= 0;  stall_pct <= 0;  end
        1: begin idle_pct <= 51; stall_pct <= 0;  end
        2: begin idle_pct <= 0;  stall_pct <= 51; end
        default: begin idle_pct <= 23; stall_pct <= 23; end
      endcase
      if (ph == 0) begin
        // receiver holds off while long replies pile up behind it
        long_hold_go <= 1'b1;
        repeat (6) send_cmd3(CMD_GET_Y, 8'($urandom), 8'($urandom), 8'($urandom),
                             Y_W'($urandom));
      end
      target = req_count + 18;
      while (req_count < target) random_seq();
      drain_results();
    end

    $display("tb_top: %0d requests in %0d frames, %0d results checked",
             req_count, frame_count, results_seen);
    $display("tb_top: all commands, crc/length/command drops, pulses, four idle/stall mixes");
    if (fail_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/fspb_pkg.sv
hw/rtl/fspb_if.sv
hw/rtl/fspb_frame.sv
hw/rtl/fspb_txq.sv
hw/rtl/framed_serial_port_bridge_top.sv
tb/fspb_checker.sv
tb/tb_top.sv
